// ===== src/eeu_pkg.sv =====
package eeu_pkg;

    localparam int OPW = 31;                    // operand width
    localparam int CW = 32;                     // coefficient width
    localparam int CNTW = $clog2(OPW);          // divider bit counter width
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(OPW - 1);

    typedef struct packed {
        logic [OPW-1:0] modulus;
        logic [OPW-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] coef_x;
        logic signed [CW-1:0] coef_y;
        logic [OPW-1:0]       inverse;
        logic                 order_error;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul;
        logic upd;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic order_err;
        logic r1_zero;
        logic div_last;
    } t_dp_sts;

endpackage

// ===== src/eeu_datapath.sv =====
module eeu_datapath
    import eeu_pkg::*;
(
    input  logic    i_clk,
    input  t_in     i_in_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_out    o_result
);

    logic [OPW-1:0]  r_a, r_r0, r_r1, r_rem, r_quo;
    logic [CW-1:0]   r_s0, r_s1, r_t0, r_t1, r_ps, r_pt;
    logic            r_err;
    logic [CNTW-1:0] r_cnt;

    logic [OPW:0]    rem_sh;
    logic            q_bit;
    logic [OPW:0]    rem_sub;
    logic [2*CW-1:0] ps_full, pt_full;
    logic [CW-1:0]   inv_sum;

    // One restoring division bit: shift in the next dividend bit, subtract if it fits.
    assign rem_sh  = {r_rem, r_quo[OPW-1]};
    assign rem_sub = rem_sh - {1'b0, r_r1};
    assign q_bit   = (rem_sh >= {1'b0, r_r1});

    // Coefficients only matter modulo 2^CW, so an unsigned product is enough.
    assign ps_full = {1'b0, r_quo} * r_s1;
    assign pt_full = {1'b0, r_quo} * r_t1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a   <= i_in_data.modulus;
            r_r0  <= i_in_data.modulus;
            r_r1  <= i_in_data.value;
            r_err <= (i_in_data.modulus <= i_in_data.value);
            r_s0  <= CW'(1);
            r_s1  <= '0;
            r_t0  <= '0;
            r_t1  <= CW'(1);
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_r0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[OPW-1:0] : rem_sh[OPW-1:0];
            r_quo <= {r_quo[OPW-2:0], q_bit};
            r_cnt <= r_cnt + CNTW'(1);
        end
        if (i_cmd.mul) begin
            r_ps <= ps_full[CW-1:0];
            r_pt <= pt_full[CW-1:0];
        end
        if (i_cmd.upd) begin
            r_r0 <= r_r1;
            r_r1 <= r_rem;
            r_s0 <= r_s1;
            r_s1 <= r_s0 - r_ps;
            r_t0 <= r_t1;
            r_t1 <= r_t0 - r_pt;
        end
    end

    assign o_sts.order_err = r_err;
    assign o_sts.r1_zero   = (r_r1 == '0);
    assign o_sts.div_last  = (r_cnt == DIV_LAST);

    assign inv_sum = r_t0 + {1'b0, r_a};

    always_comb begin
        if (r_err) begin
            o_result.coef_x      = '0;
            o_result.coef_y      = '0;
            o_result.inverse     = '0;
            o_result.order_error = 1'b1;
        end else begin
            o_result.coef_x      = r_s0;
            o_result.coef_y      = r_t0;
            o_result.inverse     = r_t0[CW-1] ? inv_sum[OPW-1:0] : r_t0[OPW-1:0];
            o_result.order_error = 1'b0;
        end
    end

endmodule

// ===== src/eeu_ctrl.sv =====
module eeu_ctrl
    import eeu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.order_err || i_sts.r1_zero) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_CHECK;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.div_init = !(i_sts.order_err || i_sts.r1_zero);
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_MUL:  o_cmd.mul = 1'b1;
            ST_UPD:  o_cmd.upd = 1'b1;
            ST_DONE: o_cmd.res_load = i_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/extended_euclid_mod_inverse_unit.sv =====
// Extended Euclidean modular inverse unit. Each transfer on the input channel carries a
// modulus a and a value b, and produces one transfer on the output channel with Bezout
// coefficients x and y (a*x + b*y = gcd(a, b), two's complement), and y reduced into
// [0, a), which is the inverse of b modulo a when the two are coprime. Coprimality is not
// checked. When a is not greater than b, order_error is set and the other fields are zero.
// Items are processed one at a time. Every Euclid step runs a restoring divider that
// retires one quotient bit per cycle, after a setup and before the coefficient multiply
// and update. An item takes at most 44 division steps for 31-bit operands. Results with
// an order error or a zero value finish without any division step. A finished result
// waits in an output register, and the next input is accepted as soon as it has been
// stored.
module extended_euclid_mod_inverse_unit
    import eeu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_out    result;
    logic    out_free;

    logic    r_out_valid;
    t_out    r_out;

    // The output register can take a new result when empty or when its transfer completes.
    assign out_free = !r_out_valid || i_out_ready;

    eeu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    eeu_datapath u_dp (
        .i_clk     (i_clk),
        .i_in_data (i_in_data),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register needs no reset; it is only read while valid.
    always_ff @(posedge i_clk) begin
        if (cmd.res_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
